### rtl/core/tlf_pkg.sv
// Shared types and constants for the terminator line framer.
// Used by every module of the framer core; depends on nothing else.
package tlf_pkg;

    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 7;
    localparam int IDX_W         = 6;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int TERM_CAPACITY = 16;
    localparam int TERM_CNT_W    = 5;
    localparam int CHARS_PER_REG = 8;
    localparam int OQ_DEPTH      = 4;
    localparam int OQ_PTR_W      = 2;
    localparam int OQ_CNT_W      = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TERM_LOW    = 3'd0,
        REG_TERM_HIGH   = 3'd1,
        REG_TERM_COUNT  = 3'd2,
        REG_TRIM_ENABLE = 3'd3,
        REG_FRAME_LIMIT = 3'd4
    } reg_idx_t;

    // Frame end causes
    localparam logic REASON_TERM = 1'b0;
    localparam logic REASON_FULL = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } back_state_t;

    // One finished frame waiting to be read out
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             reason;
    } desc_t;

    // Buffer write from the front part
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    // Bank handed back by the back part
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              reason;
        logic [LEN_W-1:0]  len;
    } out_item_t;

endpackage

### rtl/core/tlf_front.sv
// Front part of the framer: configuration registers, byte intake,
// terminator match and frame closing. Depends on tlf_pkg.
module tlf_front #(
    parameter int BUF_DEPTH = 64,
    parameter int MAX_TERMS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlf_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           push,
    input  logic [tlf_pkg::BYTE_W-1:0]     rx_byte,
    output logic                           full,
    output tlf_pkg::mem_wr_t               mem_wr,
    output tlf_pkg::desc_t                 desc,
    output logic                           desc_push,
    input  tlf_pkg::rel_t                  rel
);
    import tlf_pkg::*;

    logic [CFG_W-1:0]      term_lo_reg;
    logic [CFG_W-1:0]      term_hi_reg;
    logic [TERM_CNT_W-1:0] term_cnt_reg;
    logic                  trim_reg;
    logic [LEN_W-1:0]      limit_reg;

    logic [LEN_W-1:0]      fill_reg, fill_next;
    logic                  bank_reg, bank_next;
    logic [1:0]            busy_reg, busy_next;

    logic                  accept;
    logic                  is_term;
    logic [LEN_W-1:0]      eff_lim;
    logic [LEN_W-1:0]      new_fill;
    logic [LEN_W-1:0]      term_len;
    logic                  at_limit;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            term_lo_reg  <= '0;
            term_hi_reg  <= '0;
            term_cnt_reg <= '0;
            trim_reg     <= 1'b0;
            limit_reg    <= LEN_W'(64);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TERM_LOW:    term_lo_reg  <= cfg_data;
                REG_TERM_HIGH:   term_hi_reg  <= cfg_data;
                REG_TERM_COUNT:  term_cnt_reg <= cfg_data[TERM_CNT_W-1:0];
                REG_TRIM_ENABLE: trim_reg     <= cfg_data[0];
                REG_FRAME_LIMIT: limit_reg    <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Match the byte against every terminator slot in use
    always_comb begin
        logic [BYTE_W-1:0] ch;
        is_term = 1'b0;
        for (int j = 0; j < MAX_TERMS; j++) begin
            if (j < CHARS_PER_REG) begin
                ch = term_lo_reg[(j % CHARS_PER_REG)*BYTE_W +: BYTE_W];
            end else begin
                ch = term_hi_reg[(j % CHARS_PER_REG)*BYTE_W +: BYTE_W];
            end
            if ((term_cnt_reg > TERM_CNT_W'(j)) && (ch == rx_byte)) begin
                is_term = 1'b1;
            end
        end
    end

    // Clamp the frame limit into 1..BUF_DEPTH
    always_comb begin
        priority if (limit_reg == '0) begin
            eff_lim = LEN_W'(1);
        end else if (limit_reg > LEN_W'(BUF_DEPTH)) begin
            eff_lim = LEN_W'(BUF_DEPTH);
        end else begin
            eff_lim = limit_reg;
        end
    end

    // Classify the incoming byte
    assign full     = busy_reg[bank_reg];
    assign accept   = push && !full;
    assign new_fill = fill_reg + LEN_W'(1);
    assign term_len = new_fill - LEN_W'(trim_reg);
    assign at_limit = new_fill >= eff_lim;

    assign desc_push = accept && (is_term ? (term_len != '0) : at_limit);
    assign desc.bank   = bank_reg;
    assign desc.len    = is_term ? term_len : new_fill;
    assign desc.reason = is_term ? REASON_TERM : REASON_FULL;

    // Store the byte in the current bank
    assign mem_wr.en   = accept;
    assign mem_wr.bank = bank_reg;
    assign mem_wr.idx  = fill_reg[IDX_W-1:0];
    assign mem_wr.data = rx_byte;

    // Advance fill, swap banks on a closed frame, track bank ownership
    always_comb begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (accept) begin
            fill_next = (is_term || at_limit) ? '0 : new_fill;
        end
        if (rel.en) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (desc_push) begin
            busy_next[bank_reg] = 1'b1;
            bank_next           = ~bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fill_reg <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end else begin
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

### rtl/core/tlf_desc_q.sv
// Two-entry queue of closed-frame descriptors between front and back.
// Depends on tlf_pkg.
module tlf_desc_q (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tlf_pkg::desc_t wr_desc,
    output logic           q_full,
    input  logic           rd_en,
    output tlf_pkg::desc_t rd_desc,
    output logic           q_empty
);
    import tlf_pkg::*;

    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign q_full  = cnt_reg == 2'd2;
    assign q_empty = cnt_reg == 2'd0;
    assign rd_desc = entry_reg[rd_ptr_reg];

    // Hold descriptors
    always_ff @(posedge clk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

### rtl/core/tlf_back.sv
// Back part of the framer: two-bank frame buffer, frame readout sequencer
// and result queue. Depends on tlf_pkg.
module tlf_back #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tlf_pkg::mem_wr_t            mem_wr,
    input  tlf_pkg::desc_t              dq_desc,
    input  logic                        dq_empty,
    output logic                        dq_pop,
    output tlf_pkg::rel_t               rel,
    output logic                        empty,
    input  logic                        pop,
    output logic [tlf_pkg::BYTE_W-1:0]  out_byte,
    output logic                        out_last,
    output logic                        out_reason,
    output logic [tlf_pkg::LEN_W-1:0]   frame_length
);
    import tlf_pkg::*;

    localparam int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int MEM_DEPTH = 2 * (1 << AW);

    logic [BYTE_W-1:0] mem [MEM_DEPTH];

    back_state_t       state_reg, state_next;
    desc_t             cur_reg;
    logic [LEN_W-1:0]  k_reg;

    logic              issue;
    logic              credit;
    logic              last_k;

    logic              rd_valid_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_last_reg;
    logic              rd_reason_reg;
    logic [LEN_W-1:0]  rd_len_reg;

    out_item_t           oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg;
    logic [OQ_PTR_W-1:0] oq_rd_reg;
    logic [OQ_CNT_W-1:0] oq_cnt_reg;
    logic                oq_pop;
    out_item_t           oq_head;

    // Room in the result queue for everything already in flight
    assign credit = (oq_cnt_reg + OQ_CNT_W'(rd_valid_reg)) < OQ_CNT_W'(OQ_DEPTH);
    assign last_k = k_reg == (cur_reg.len - LEN_W'(1));

    // Next state of the readout sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!dq_empty) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (credit && last_k) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        dq_pop   = 1'b0;
        issue    = 1'b0;
        unique case (state_reg)
            ST_IDLE: dq_pop = !dq_empty;
            ST_RUN:  issue  = credit;
            default: ;
        endcase
        rel.en   = issue && last_k;
        rel.bank = cur_reg.bank;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
        end
    end

    // Load a frame and step through its bytes
    always_ff @(posedge clk) begin
        if (dq_pop) begin
            cur_reg <= dq_desc;
            k_reg   <= '0;
        end else if (issue) begin
            k_reg <= k_reg + LEN_W'(1);
        end
    end

    // Frame buffer: one write port, one registered read port
    always_ff @(posedge clk) begin
        if (mem_wr.en) begin
            mem[{mem_wr.bank, mem_wr.idx[AW-1:0]}] <= mem_wr.data;
        end
        if (issue) begin
            rd_data_reg   <= mem[{cur_reg.bank, k_reg[AW-1:0]}];
            rd_last_reg   <= last_k;
            rd_reason_reg <= cur_reg.reason;
            rd_len_reg    <= cur_reg.len;
        end
    end

    // Result queue
    assign oq_pop       = pop && !empty;
    assign empty        = oq_cnt_reg == '0;
    assign oq_head      = oq_reg[oq_rd_reg];
    assign out_byte     = oq_head.data;
    assign out_last     = oq_head.last;
    assign out_reason   = oq_head.reason;
    assign frame_length = oq_head.len;

    always_ff @(posedge clk) begin
        if (rd_valid_reg) begin
            oq_reg[oq_wr_reg] <= '{data: rd_data_reg, last: rd_last_reg,
                                   reason: rd_reason_reg, len: rd_len_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end else begin
            if (rd_valid_reg) begin
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            end
            oq_cnt_reg <= oq_cnt_reg + OQ_CNT_W'(rd_valid_reg) - OQ_CNT_W'(oq_pop);
        end
    end

endmodule

### rtl/core/terminator_line_framer_core.sv
// Top level of the terminator line framer core.
// Instantiates tlf_front, tlf_desc_q and tlf_back; depends on tlf_pkg.
//
// Usage:
//   Input queue: drive rx_byte and raise push; the byte is taken at an edge
//   where push is high and full is low. Result queue: while empty is low the
//   oldest result (out_byte, out_last, out_reason, frame_length) is shown and
//   is taken at an edge where pop is high.
//   Configuration: cfg_we with cfg_index/cfg_data writes one register;
//   write only while the framer is idle.
// Timing:
//   The front takes one byte per cycle while full is low. The frame buffer
//   has two banks; a frame is read out of one bank while the next frame
//   fills the other, and full rises when the bank to be filled still holds
//   an unread frame. Readout loads a frame descriptor, then reads one byte
//   per cycle from the single buffer read port while the result queue has
//   room. With the back part idle, a closed frame passes the descriptor
//   queue, the frame register, the buffer read register and the result
//   queue before its first byte is shown; it can be popped at the next edge.
// Reset and stall:
//   Reset clears fill count, bank ownership and both queues; buffer contents
//   are left as they are. When the receiver stops popping, the 4-entry result
//   queue fills, readout halts, and full rises once both banks hold frames.
module terminator_line_framer_core #(
    parameter int BUF_DEPTH = 64,
    parameter int MAX_TERMS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tlf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [tlf_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [tlf_pkg::BYTE_W-1:0]    out_byte,
    output logic                          out_last,
    output logic                          out_reason,
    output logic [tlf_pkg::LEN_W-1:0]     frame_length
);
    import tlf_pkg::*;

    mem_wr_t mem_wr;
    desc_t   desc;
    desc_t   dq_desc;
    rel_t    rel;
    logic    desc_push;
    logic    dq_full;
    logic    dq_empty;
    logic    dq_pop;

    tlf_front #(
        .BUF_DEPTH (BUF_DEPTH),
        .MAX_TERMS (MAX_TERMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .mem_wr    (mem_wr),
        .desc      (desc),
        .desc_push (desc_push),
        .rel       (rel)
    );

    tlf_desc_q u_desc_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_desc (desc),
        .q_full  (dq_full),
        .rd_en   (dq_pop),
        .rd_desc (dq_desc),
        .q_empty (dq_empty)
    );

    tlf_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mem_wr       (mem_wr),
        .dq_desc      (dq_desc),
        .dq_empty     (dq_empty),
        .dq_pop       (dq_pop),
        .rel          (rel),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .out_reason   (out_reason),
        .frame_length (frame_length)
    );

    // Bank ownership must keep the descriptor queue from overflowing
    a_dq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(desc_push && dq_full))
        else $error("descriptor pushed into a full queue");

    // Back part only loads a descriptor that is there
    a_dq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(dq_pop && dq_empty))
        else $error("descriptor popped from an empty queue");

    // Every shown result belongs to a frame of at least one byte
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_length != '0))
        else $error("result shown with zero frame length");

    // A bank is only handed back while the front is not closing into it
    a_rel_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (rel.en && desc_push) |-> (rel.bank != desc.bank))
        else $error("bank released while being closed");

endmodule

### sim/tb_terminator_line_framer_core.sv
// Self-checking testbench for terminator_line_framer_core: directed and random byte streams
// against a line framing predictor, with random idling on both queue sides.
// Depends on tlf_pkg and the framer core RTL.
module tb_terminator_line_framer_core;
    import tlf_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_GAP      = 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 130;
    localparam int BUF_BYTES    = 64;

    // Index outside the register map; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;

    // Directed terminator table: newline twice (entries 0 and 4), 0x00 and 0xFF,
    // and 0x7E in the last entry of the upper word
    localparam logic [CFG_W-1:0] DIR_TERM_LOW  = 64'h09_2C_3B_0A_FF_00_0D_0A;
    localparam logic [CFG_W-1:0] DIR_TERM_HIGH = 64'h7E_5C_7C_20_FE_01_7F_80;

    // Line framing predictor and store of expected output bytes
    class framer_scoreboard;
        localparam int LINE_DEPTH = 64;
        localparam int REPORT_MAX = 10;

        logic [CFG_W-1:0]      term_low;
        logic [CFG_W-1:0]      term_high;
        logic [TERM_CNT_W-1:0] term_count;
        logic                  trim;
        logic [LEN_W-1:0]      limit;
        logic [BYTE_W-1:0]     line_buf [LINE_DEPTH];
        int unsigned           fill;
        out_item_t             expected_q [$];
        int unsigned           failures;
        int unsigned           checked;

        function new();
            term_low   = '0;
            term_high  = '0;
            term_count = '0;
            trim       = 1'b0;
            limit      = 7'd64;
            fill       = 0;
            failures   = 0;
            checked    = 0;
        endfunction

        // Mirror a register write; unknown indexes are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_TERM_LOW:    term_low = val;
                REG_TERM_HIGH:   term_high = val;
                REG_TERM_COUNT:  term_count = val[TERM_CNT_W-1:0];
                REG_TRIM_ENABLE: trim = val[0];
                REG_FRAME_LIMIT: limit = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Counts above the table size act as the full table
        function int unsigned active_terms();
            if (term_count > TERM_CAPACITY)
            begin
                return TERM_CAPACITY;
            end
            return term_count;
        endfunction

        function logic [BYTE_W-1:0] term_char(int unsigned j);
            if (j < CHARS_PER_REG)
            begin
                return term_low[j*BYTE_W +: BYTE_W];
            end
            return term_high[(j-CHARS_PER_REG)*BYTE_W +: BYTE_W];
        endfunction

        function void queue_frame(int unsigned len, logic reason);
            out_item_t item;
            for (int unsigned k = 0; k < len; k++)
            begin
                item.data   = line_buf[k];
                item.last   = (k + 1 == len);
                item.reason = reason;
                item.len    = LEN_W'(len);
                expected_q.push_back(item);
            end
        endfunction

        // Store one accepted byte, then close the line on a terminator or a full buffer
        function void note_byte(logic [BYTE_W-1:0] b);
            bit          hit;
            int unsigned lim;
            int unsigned len;
            hit = 1'b0;
            line_buf[fill] = b;
            fill++;
            for (int unsigned j = 0; j < active_terms(); j++)
            begin
                if (term_char(j) == b)
                begin
                    hit = 1'b1;
                end
            end
            if (hit)
            begin
                // terminator wins over a full buffer; trimmed empty lines vanish
                len = trim ? fill - 1 : fill;
                if (len != 0)
                begin
                    queue_frame(len, REASON_TERM);
                end
                fill = 0;
            end
            else
            begin
                lim = limit;
                if (lim < 1)
                begin
                    lim = 1;
                end
                if (lim > LINE_DEPTH)
                begin
                    lim = LINE_DEPTH;
                end
                if (fill >= lim)
                begin
                    queue_frame(fill, REASON_FULL);
                    fill = 0;
                end
            end
        endfunction

        // Compare one popped item with the oldest expected one
        function void check_item(out_item_t got);
            out_item_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                begin
                    $display("unexpected item %0d: byte %02h last %b reason %b length %0d",
                             checked, got.data, got.last, got.reason, got.len);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.data !== want.data || got.last !== want.last ||
                got.reason !== want.reason || got.len !== want.len)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                begin
                    $display("item %0d mismatch: expected byte %02h last %b reason %b length %0d",
                             checked, want.data, want.last, want.reason, want.len);
                    $display("    got byte %02h last %b reason %b length %0d",
                             got.data, got.last, got.reason, got.len);
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  push      = 1'b0;
    logic [BYTE_W-1:0]     rx_byte   = '0;
    logic                  pop       = 1'b0;
    logic                  full;
    logic                  empty;
    logic [BYTE_W-1:0]     out_byte;
    logic                  out_last;
    logic                  out_reason;
    logic [LEN_W-1:0]      frame_length;

    framer_scoreboard sb;
    int unsigned      tx_max_gap = MAX_GAP;
    int unsigned      rx_max_gap = MAX_GAP;
    int unsigned      items_sent = 0;
    int unsigned      reg_writes = 0;
    int unsigned      phases     = 0;
    int unsigned      cycles     = 0;

    terminator_line_framer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .out_reason   (out_reason),
        .frame_length (frame_length)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycles, sb.expected_q.size());
            $display("terminator_line_framer_core verification failed");
            $finish;
        end
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic send_byte(logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (full !== 1'b0);
        sb.note_byte(b);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_seq(logic [BYTE_W-1:0] seq [$]);
        foreach (seq[i])
        begin
            send_byte(seq[i]);
        end
    endtask

    // Random body, then one terminator from the table in use when asked
    task automatic send_random_line(bit with_end);
        int unsigned body;
        body = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        repeat (body) send_byte(BYTE_W'($urandom));
        if (with_end && sb.active_terms() != 0)
        begin
            send_byte(sb.term_char($urandom_range(0, sb.active_terms() - 1)));
        end
    endtask

    // Drop push, wait until every expected item is out, then let the core settle
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        sb.write_reg(idx, val);
        reg_writes++;
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Draw a register setting and idling mode for the next phase
    task automatic random_setup();
        logic [TERM_CNT_W-1:0] cnt;
        logic [LEN_W-1:0]      lim;
        case ($urandom_range(0, 5))
            0:       cnt = '0;
            1:       cnt = 5'd1;
            2:       cnt = 5'd16;
            3:       cnt = TERM_CNT_W'($urandom_range(17, 31));
            default: cnt = TERM_CNT_W'($urandom_range(2, 15));
        endcase
        case ($urandom_range(0, 6))
            0:       lim = '0;
            1:       lim = 7'd1;
            2:       lim = 7'd64;
            3:       lim = LEN_W'($urandom_range(65, 127));
            4:       lim = LEN_W'($urandom_range(9, 63));
            default: lim = LEN_W'($urandom_range(2, 8));
        endcase
        set_reg(REG_TERM_LOW, {$urandom, $urandom});
        set_reg(REG_TERM_HIGH, {$urandom, $urandom});
        set_reg(REG_TERM_COUNT, CFG_W'(cnt));
        set_reg(REG_TRIM_ENABLE, CFG_W'($urandom_range(0, 1)));
        set_reg(REG_FRAME_LIMIT, CFG_W'(lim));
        if ($urandom_range(0, 3) == 0)
        begin
            set_reg(UNUSED_REG_IDX, {$urandom, $urandom});
        end
        tx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
        rx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
        phases++;
    endtask

    // Result side: pop after a random gap, check each item taken
    task automatic pop_item();
        int unsigned gap;
        out_item_t   got;
        gap = $urandom_range(0, rx_max_gap);
        if (gap != 0)
        begin
            pop <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pop <= 1'b1;
        do @(posedge clk); while (empty !== 1'b0);
        got.data   = out_byte;
        got.last   = out_last;
        got.reason = out_reason;
        got.len    = frame_length;
        sb.check_item(got);
        @(negedge clk);
    endtask

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever pop_item();
    end

    initial
    begin
        int unsigned start_count;
        int unsigned phase_end;
        int unsigned sel;
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full terminator table, duplicate newline, extreme byte values
        set_reg(REG_TERM_LOW, DIR_TERM_LOW);
        set_reg(REG_TERM_HIGH, DIR_TERM_HIGH);
        set_reg(REG_TERM_COUNT, CFG_W'(16));
        set_reg(REG_TRIM_ENABLE, '0);
        set_reg(REG_FRAME_LIMIT, CFG_W'(64));
        set_reg(UNUSED_REG_IDX, '1);
        phases++;
        send_seq('{8'h61, 8'h62, 8'h0A, 8'h00, 8'hFF, 8'h7E, 8'h41, 8'h0A});

        // Trim: terminator dropped, lone terminator gives no line
        wait_idle();
        set_reg(REG_TRIM_ENABLE, CFG_W'(1));
        phases++;
        send_seq('{8'h78, 8'h0D, 8'h0D, 8'h55, 8'hAA, 8'h09});

        // Small limit: buffer-full line, then terminator landing on a full buffer
        wait_idle();
        set_reg(REG_TRIM_ENABLE, '0);
        set_reg(REG_FRAME_LIMIT, CFG_W'(3));
        phases++;
        send_seq('{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h2C});

        // Lower the limit below a partly filled buffer
        wait_idle();
        set_reg(REG_FRAME_LIMIT, CFG_W'(64));
        send_seq('{8'h12, 8'h34, 8'h56, 8'h78});
        wait_idle();
        set_reg(REG_FRAME_LIMIT, CFG_W'(2));
        phases++;
        send_seq('{8'h9A});

        // Limit zero acts as one; oversized count acts as the full table
        wait_idle();
        set_reg(REG_FRAME_LIMIT, '0);
        set_reg(REG_TERM_COUNT, CFG_W'(31));
        phases++;
        send_seq('{8'hC3, 8'h7E});

        // One line that fills the whole buffer under an oversized limit
        wait_idle();
        set_reg(REG_TERM_COUNT, '0);
        set_reg(REG_FRAME_LIMIT, CFG_W'(127));
        phases++;
        start_count = items_sent;
        repeat (BUF_BYTES - sb.fill) send_byte(BYTE_W'($urandom));

        // Random phases: mostly terminated lines, some noise and broken lines
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            wait_idle();
            random_setup();
            phase_end = items_sent + $urandom_range(12, 20);
            while (items_sent < phase_end)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                begin
                    send_random_line(1'b1);
                end
                else if (sel < 9)
                begin
                    send_byte(BYTE_W'($urandom));
                end
                else
                begin
                    send_random_line(1'b0);
                end
            end
        end

        wait_idle();
        $display("sent %0d bytes over %0d phases and %0d register writes",
                 items_sent, phases, reg_writes);
        $display("checked %0d output items, %0d failures", sb.checked, sb.failures);
        if (sb.failures == 0 && sb.expected_q.size() == 0)
        begin
            $display("terminator_line_framer_core verification clean");
        end
        else
        begin
            $display("terminator_line_framer_core verification failed");
        end
        $finish;
    end

endmodule
